>>> hdl/bf2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf2d_pkg
// Shared constants, register indexes and controller/datapath link types.
// ----------------------------------------------------------------------------
package bf2d_pkg;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int DEF_MAX_RADIUS = 7;

   localparam int WIDTH_W    = 12;
   localparam int HEIGHT_W   = 13;
   localparam int RADIUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int PIXEL_W    = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_RADIUS = 2'd2;

   // input word op codes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 12'd640;
   localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 13'd480;
   localparam logic [RADIUS_W-1:0] RST_RADIUS = 3'd1;

   localparam int SUM_W     = 16;  // 225 * 255 fits
   localparam int DIVISOR_W = 8;   // side squared, at most 225
   localparam int DIV_CNT_W = 4;
   localparam int TOTAL_W   = 25;
   localparam int POS_W     = 26;
   localparam int DELAY_W   = 15;
   localparam int ROW_W     = 13;
   localparam int COL_W     = 12;
   localparam int COORD_W   = 14;
   localparam int TAP_W     = RADIUS_W + 1;

   typedef struct packed {
      logic accept;
      logic scan;
      logic div_load;
      logic div_step;
      logic send_done;
   } cmd_type;

   typedef struct packed {
      logic needs_out;
      logic scan_last;
      logic div_last;
   } status_type;

endpackage

>>> hdl/bf2d_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf2d_dp
// Datapath: registers, line store, window scan, accumulator and divider.
// ----------------------------------------------------------------------------
module bf2d_dp #(
   parameter int MAX_WIDTH  = bf2d_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bf2d_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = bf2d_pkg::DEF_MAX_RADIUS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [bf2d_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bf2d_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_op,
   input  logic [bf2d_pkg::PIXEL_W-1:0]        req_pixel,
   input  bf2d_pkg::cmd_type                   cmd,
   output bf2d_pkg::status_type                status,
   output logic [bf2d_pkg::PIXEL_W-1:0]        rsp_filtered_pixel,
   output logic                                rsp_last_pixel
);

   localparam int DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW:0]   DEPTH_X = (AW+1)'(DEPTH);
   localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

   localparam int WW = bf2d_pkg::WIDTH_W;
   localparam int HW = bf2d_pkg::HEIGHT_W;
   localparam int RW = bf2d_pkg::RADIUS_W;
   localparam int CW = bf2d_pkg::COORD_W;
   localparam int SW = bf2d_pkg::SUM_W;
   localparam int DW = bf2d_pkg::DIVISOR_W;

   logic [WW-1:0] width_ff;
   logic [HW-1:0] height_ff;
   logic [RW-1:0] radius_ff;

   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [RW-1:0] r_eff;
   logic [bf2d_pkg::TOTAL_W-1:0] total;
   logic [bf2d_pkg::DELAY_W-1:0] delay;
   logic [bf2d_pkg::DELAY_W:0]   two_delay;
   logic [bf2d_pkg::TAP_W-1:0]   tap_max;
   logic [DW-1:0]                side2;

   logic [bf2d_pkg::POS_W-1:0] pos_ff;
   logic [AW-1:0]              wr_addr_ff;
   logic [AW-1:0]              wr_addr_next;
   logic [bf2d_pkg::ROW_W-1:0] out_row_ff;
   logic [bf2d_pkg::COL_W-1:0] out_col_ff;
   logic                       is_last;

   logic [AW-1:0] row_addr_ff;
   logic [AW-1:0] col_addr_ff;
   logic [AW:0]   start_wide;
   logic [AW-1:0] start_addr;
   logic [AW:0]   row_sum;
   logic [AW-1:0] row_next;
   logic [AW-1:0] col_next;
   logic [bf2d_pkg::TAP_W-1:0] cnt_x_ff;
   logic [bf2d_pkg::TAP_W-1:0] cnt_y_ff;
   logic [CW-1:0] yy_ff;
   logic [CW-1:0] xx_ff;
   logic [CW-1:0] xx_first;
   logic          in_window;

   logic [7:0]    mem [DEPTH];
   logic [7:0]    rd_data_ff;
   logic          mask_ff;
   logic          take_ff;
   logic [SW-1:0] sum_ff;
   logic          wr_en;

   logic [DW-1:0] rem_ff;
   logic [SW-1:0] dq_ff;
   logic [bf2d_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [DW:0]   shifted;
   logic [DW:0]   diff;
   logic          q_bit;

   logic [7:0] pix_ff;
   logic       last_ff;

   // effective, clamped configuration
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = HW'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      if (int'(radius_ff) > MAX_RADIUS) begin
         r_eff = RW'(MAX_RADIUS);
      end else begin
         r_eff = radius_ff;
      end
   end

   assign total     = bf2d_pkg::TOTAL_W'(w_eff) * bf2d_pkg::TOTAL_W'(h_eff);
   assign delay     = bf2d_pkg::DELAY_W'(r_eff) * bf2d_pkg::DELAY_W'(w_eff)
                      + bf2d_pkg::DELAY_W'(r_eff);
   assign two_delay = {delay, 1'b0};
   assign tap_max   = {r_eff, 1'b0};
   assign side2     = DW'({r_eff, 1'b1}) * DW'({r_eff, 1'b1});

   assign wr_addr_next = (wr_addr_ff == LAST_A) ? '0 : wr_addr_ff + AW'(1);
   assign is_last = (out_row_ff == h_eff - HW'(1)) && (out_col_ff == w_eff - WW'(1));

   // oldest window tap sits 2*delay words behind the write pointer
   always_comb begin
      if ({1'b0, wr_addr_ff} >= (AW+1)'(two_delay)) begin
         start_wide = {1'b0, wr_addr_ff} - (AW+1)'(two_delay);
      end else begin
         start_wide = {1'b0, wr_addr_ff} + DEPTH_X - (AW+1)'(two_delay);
      end
   end
   assign start_addr = start_wide[AW-1:0];

   assign row_sum  = {1'b0, row_addr_ff} + (AW+1)'(w_eff);
   assign row_next = (row_sum >= DEPTH_X) ? AW'(row_sum - DEPTH_X) : row_sum[AW-1:0];
   assign col_next = (col_addr_ff == LAST_A) ? '0 : col_addr_ff + AW'(1);
   assign xx_first = CW'(out_col_ff) - CW'(r_eff);

   assign in_window = !yy_ff[CW-1] && (yy_ff < CW'(h_eff)) &&
                      !xx_ff[CW-1] && (xx_ff < CW'(w_eff));

   assign wr_en = cmd.accept && (pos_ff < bf2d_pkg::POS_W'(total));

   // restoring divide, one quotient bit a cycle
   assign shifted = {rem_ff, dq_ff[SW-1]};
   assign q_bit   = shifted >= {1'b0, side2};
   assign diff    = shifted - {1'b0, side2};

   assign status.needs_out = pos_ff >= bf2d_pkg::POS_W'(delay);
   assign status.scan_last = (cnt_x_ff == tap_max) && (cnt_y_ff == tap_max);
   assign status.div_last  = div_cnt_ff == bf2d_pkg::DIV_CNT_W'(SW - 1);

   // line store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr_ff] <= (req_op == bf2d_pkg::OP_FLUSH) ? 8'd0 : req_pixel;
      end
      if (cmd.scan) begin
         rd_data_ff <= mem[col_addr_ff];
      end
   end

   // control and frame position
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= bf2d_pkg::RST_WIDTH;
         height_ff  <= bf2d_pkg::RST_HEIGHT;
         radius_ff  <= bf2d_pkg::RST_RADIUS;
         pos_ff     <= '0;
         wr_addr_ff <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         take_ff    <= 1'b0;
      end else begin
         take_ff <= cmd.scan;
         if (csr_write) begin
            case (csr_index)
               bf2d_pkg::CSR_IMAGE_WIDTH: begin
                  width_ff <= csr_wdata[WW-1:0];
               end
               bf2d_pkg::CSR_IMAGE_HEIGHT: begin
                  height_ff <= csr_wdata[HW-1:0];
               end
               bf2d_pkg::CSR_WINDOW_RADIUS: begin
                  radius_ff <= csr_wdata[RW-1:0];
               end
               default: begin
               end
            endcase
            if (csr_index == bf2d_pkg::CSR_IMAGE_WIDTH ||
                csr_index == bf2d_pkg::CSR_IMAGE_HEIGHT ||
                csr_index == bf2d_pkg::CSR_WINDOW_RADIUS) begin
               pos_ff     <= '0;
               wr_addr_ff <= '0;
               out_row_ff <= '0;
               out_col_ff <= '0;
            end
         end else if (cmd.accept && !status.needs_out) begin
            pos_ff     <= pos_ff + bf2d_pkg::POS_W'(1);
            wr_addr_ff <= wr_addr_next;
         end else if (cmd.send_done) begin
            if (last_ff) begin
               pos_ff     <= '0;
               wr_addr_ff <= '0;
               out_row_ff <= '0;
               out_col_ff <= '0;
            end else begin
               pos_ff     <= pos_ff + bf2d_pkg::POS_W'(1);
               wr_addr_ff <= wr_addr_next;
               if (out_col_ff == w_eff - WW'(1)) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + bf2d_pkg::ROW_W'(1);
               end else begin
                  out_col_ff <= out_col_ff + bf2d_pkg::COL_W'(1);
               end
            end
         end
      end
   end

   // window scan, accumulate, divide
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         row_addr_ff <= start_addr;
         col_addr_ff <= start_addr;
         cnt_x_ff    <= '0;
         cnt_y_ff    <= '0;
         yy_ff       <= CW'(out_row_ff) - CW'(r_eff);
         xx_ff       <= xx_first;
         sum_ff      <= '0;
      end else begin
         if (cmd.scan) begin
            mask_ff <= in_window;
            if (cnt_x_ff == tap_max) begin
               cnt_x_ff    <= '0;
               cnt_y_ff    <= cnt_y_ff + bf2d_pkg::TAP_W'(1);
               xx_ff       <= xx_first;
               yy_ff       <= yy_ff + CW'(1);
               row_addr_ff <= row_next;
               col_addr_ff <= row_next;
            end else begin
               cnt_x_ff    <= cnt_x_ff + bf2d_pkg::TAP_W'(1);
               xx_ff       <= xx_ff + CW'(1);
               col_addr_ff <= col_next;
            end
         end
         if (take_ff && mask_ff) begin
            sum_ff <= sum_ff + SW'(rd_data_ff);
         end
      end
      if (cmd.div_load) begin
         rem_ff     <= '0;
         dq_ff      <= sum_ff;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= q_bit ? diff[DW-1:0] : shifted[DW-1:0];
         dq_ff      <= {dq_ff[SW-2:0], q_bit};
         div_cnt_ff <= div_cnt_ff + bf2d_pkg::DIV_CNT_W'(1);
         if (status.div_last) begin
            pix_ff  <= {dq_ff[6:0], q_bit};
            last_ff <= is_last;
         end
      end
   end

   assign rsp_filtered_pixel = pix_ff;
   assign rsp_last_pixel     = last_ff;

endmodule

>>> hdl/bf2d_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf2d_ctrl
// Sequencer: accept, window scan, divide, hand over the result word.
// ----------------------------------------------------------------------------
module bf2d_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  bf2d_pkg::status_type status,
   output bf2d_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_LOAD,
      ST_DIV,
      ST_SEND
   } state_type;

   state_type state_ff;
   logic      stall_ff;
   logic      valid_ff;

   assign req_stall = stall_ff;
   assign rsp_valid = valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.accept    = (state_ff == ST_IDLE) && req_valid && !stall_ff;
      cmd.scan      = state_ff == ST_SCAN;
      cmd.div_load  = state_ff == ST_LOAD;
      cmd.div_step  = state_ff == ST_DIV;
      cmd.send_done = (state_ff == ST_SEND) && valid_ff && !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd.accept && status.needs_out) begin
                  state_ff <= ST_SCAN;
                  stall_ff <= 1'b1;
               end
            end
            ST_SCAN: begin
               if (status.scan_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (status.div_last) begin
                  state_ff <= ST_SEND;
                  valid_ff <= 1'b1;
               end
            end
            ST_SEND: begin
               if (!rsp_stall) begin
                  state_ff <= ST_IDLE;
                  valid_ff <= 1'b0;
                  stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               stall_ff <= 1'b0;
               valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

>>> hdl/box_filter_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_2d
// Streaming (2r+1)x(2r+1) zero-padded box mean filter over 8-bit pixels.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | req_op, req_pixel
//  rsp     | out       | rsp_valid/stall    | rsp_filtered_pixel, rsp_last_pixel
//  csr     | in        | csr_write          | csr_index, csr_wdata
//
//  A word that yields no result (start of frame, first r*W+r words) leaves
//  req_stall low. A word that yields a result holds the block through the
//  scan, divide and any rsp stall: the single read port of the line store
//  fetches one window tap a cycle, then a bit-serial divide by (2r+1)^2 runs.
//  Reset is synchronous; registers return to 640 x 480, radius 1. The line
//  store is not cleared: rows above the top are read but masked out of the sum.
//  req_stall is high from the cycle after a result-bearing word until its
//  result word has been taken.
// ----------------------------------------------------------------------------
module box_filter_2d #(
   parameter int MAX_WIDTH  = bf2d_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bf2d_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = bf2d_pkg::DEF_MAX_RADIUS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [bf2d_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bf2d_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [bf2d_pkg::PIXEL_W-1:0]    req_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bf2d_pkg::PIXEL_W-1:0]    rsp_filtered_pixel,
   output logic                            rsp_last_pixel
);

   bf2d_pkg::cmd_type    cmd;
   bf2d_pkg::status_type status;

   // sequencer: handshakes and step commands
   bf2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: line store, window sum, divider, result register
   bf2d_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_op             (req_op),
      .req_pixel          (req_pixel),
      .cmd                (cmd),
      .status             (status),
      .rsp_filtered_pixel (rsp_filtered_pixel),
      .rsp_last_pixel     (rsp_last_pixel)
   );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming box mean filter. Frames of constant
// or random pixels and flush words are driven under random idling on both sides. An
// in-bench model of the filter predicts each output pixel, and every output
// word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

   localparam int LS_DEPTH = 2 * bf2d_pkg::DEF_MAX_RADIUS * bf2d_pkg::DEF_MAX_WIDTH
                             + 2 * bf2d_pkg::DEF_MAX_RADIUS + 1;

   typedef struct packed {
      logic                         op;
      logic [bf2d_pkg::PIXEL_W-1:0] pixel;
   } in_word_type;

   typedef struct packed {
      logic [bf2d_pkg::PIXEL_W-1:0] mean;
      logic                         last;
   } out_word_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_write = 1'b0;
   logic [bf2d_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bf2d_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic                            req_op = 1'b0;
   logic [bf2d_pkg::PIXEL_W-1:0]    req_pixel = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [bf2d_pkg::PIXEL_W-1:0]    rsp_filtered_pixel;
   logic                            rsp_last_pixel;

   box_filter_2d u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---- filter model state ---------------------------------------------
   logic [bf2d_pkg::PIXEL_W-1:0] pix_ring [LS_DEPTH];
   int unsigned  m_width, m_height, m_radius;   // register contents
   int unsigned  m_row, m_col, m_outs;
   out_word_type mean_queue[$];
   in_word_type  word_queue[$];
   int           errors = 0;
   bit           quiet = 1'b0;                  // no idling in the last part

   function automatic int unsigned eff_w();
      return m_width == 0 ? 1 :
             (m_width > bf2d_pkg::DEF_MAX_WIDTH ? bf2d_pkg::DEF_MAX_WIDTH : m_width);
   endfunction
   function automatic int unsigned eff_h();
      return m_height == 0 ? 1 :
             (m_height > bf2d_pkg::DEF_MAX_HEIGHT ? bf2d_pkg::DEF_MAX_HEIGHT : m_height);
   endfunction

   // Advance the model by one accepted word, queueing its output if any.
   task automatic filter_word(in_word_type wd);
      int unsigned w, h, r, total, lag, pos, p, oy, ox, sum, side;
      int y, x;
      w = eff_w(); h = eff_h(); r = m_radius;
      total = w * h;
      lag = r * w + r;
      pos = m_row * w + m_col;
      if (pos < total)
         pix_ring[pos % LS_DEPTH] = (wd.op == bf2d_pkg::OP_FLUSH) ? 8'd0 : wd.pixel;
      if (pos < lag) begin
         m_col++;
         if (m_col >= w) begin m_col = 0; m_row++; end
         return;
      end
      p = (m_outs >= total) ? total - 1 : m_outs;
      oy = p / w; ox = p % w;
      sum = 0;
      for (int dy = -int'(r); dy <= int'(r); dy++) begin
         y = int'(oy) + dy;
         if (y < 0 || y >= int'(h)) continue;
         for (int dx = -int'(r); dx <= int'(r); dx++) begin
            x = int'(ox) + dx;
            if (x < 0 || x >= int'(w)) continue;
            sum += pix_ring[(y * w + x) % LS_DEPTH];
         end
      end
      side = 2 * r + 1;
      mean_queue.push_back('{mean: 8'(sum / (side * side)), last: p == total - 1});
      if (p == total - 1) begin
         m_row = 0; m_col = 0; m_outs = 0;
      end else begin
         m_outs = p + 1;
         m_col++;
         if (m_col >= w) begin m_col = 0; m_row++; end
      end
   endtask

   // ---- driver -----------------------------------------------------------
   int idle_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            filter_word('{op: req_op, pixel: req_pixel});
         if (!(req_valid && req_stall)) begin
            if (idle_left > 0) begin
               idle_left <= idle_left - 1;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
               idle_left <= $urandom_range(0, 4);
               req_valid <= 1'b0;
            end else if (word_queue.size() > 0) begin
               req_valid <= 1'b1;
               {req_op, req_pixel} <= word_queue.pop_front();
            end else
               req_valid <= 1'b0;
         end
      end
   end

   // ---- monitor and output stall -----------------------------------------
   int stall_left = 0;
   out_word_type seen, want;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{mean: rsp_filtered_pixel, last: rsp_last_pixel};
            if (mean_queue.size() == 0) begin
               $display("%0t: unexpected output word mean=%0d last=%0b",
                        $time, seen.mean, seen.last);
               errors++;
            end else begin
               want = mean_queue.pop_front();
               if (seen.mean !== want.mean) begin
                  $display("%0t: mean expected %0d actual %0d", $time, want.mean, seen.mean);
                  errors++;
               end
               if (seen.last !== want.last) begin
                  $display("%0t: last expected %0b actual %0b", $time, want.last, seen.last);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else
            rsp_stall <= 1'b0;
      end
   end

   // ---- stimulus ---------------------------------------------------------
   // Write one register while idle; the model is updated before the block registers it.
   task automatic csr_set(logic [bf2d_pkg::CSR_IDX_W-1:0] idx, int unsigned val);
      @(posedge clock);
      csr_write <= 1'b1; csr_index <= idx; csr_wdata <= bf2d_pkg::CSR_DATA_W'(val);
      case (idx)
         bf2d_pkg::CSR_IMAGE_WIDTH:   m_width  = val & 12'hFFF;
         bf2d_pkg::CSR_IMAGE_HEIGHT:  m_height = val & 13'h1FFF;
         bf2d_pkg::CSR_WINDOW_RADIUS: m_radius = val & 3'h7;
         default: ;
      endcase
      m_row = 0; m_col = 0; m_outs = 0;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Wait for all outputs, then let the block settle.
   task automatic drain();
      while (word_queue.size() > 0 || mean_queue.size() > 0 || req_valid)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // One frame: pixels (a few flush words mixed in when noisy), then flushes.
   task automatic frame(int unsigned w, int unsigned h, int unsigned r,
                        int mode, int noise);
      int unsigned n;
      n = w * h;
      for (int unsigned i = 0; i < n; i++) begin
         in_word_type wd;
         wd.op = (noise > 0 && $urandom_range(0, 99) < noise) ?
                 bf2d_pkg::OP_FLUSH : bf2d_pkg::OP_PIXEL;
         case (mode)
            0: wd.pixel = 8'hFF;
            1: wd.pixel = 8'h00;
            default: wd.pixel = 8'($urandom);
         endcase
         word_queue.push_back(wd);
      end
      for (int unsigned i = 0; i < r * w + r; i++)
         word_queue.push_back('{op: bf2d_pkg::OP_FLUSH, pixel: 8'($urandom)});
   endtask

   task automatic setup(int unsigned w, int unsigned h, int unsigned r);
      csr_set(bf2d_pkg::CSR_IMAGE_WIDTH, w);
      csr_set(bf2d_pkg::CSR_IMAGE_HEIGHT, h);
      csr_set(bf2d_pkg::CSR_WINDOW_RADIUS, r);
   endtask

   initial begin
      int unsigned w, h, r, sent;
      m_width = bf2d_pkg::RST_WIDTH;
      m_height = bf2d_pkg::RST_HEIGHT;
      m_radius = bf2d_pkg::RST_RADIUS;
      m_row = 0; m_col = 0; m_outs = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: full-scale and zero frames, radius 0, width 1, clamped
      // zero sizes, and pixel words after a frame standing in as flushes.
      setup(3, 3, 1);
      frame(3, 3, 1, 0, 0);
      drain();
      setup(4, 2, 0);
      frame(4, 2, 0, 1, 0);
      word_queue.push_back('{op: bf2d_pkg::OP_FLUSH, pixel: 8'hFF});   // flush in frame
      drain();
      setup(0, 0, 0);                                       // clamps to 1 x 1
      word_queue.push_back('{op: bf2d_pkg::OP_PIXEL, pixel: 8'hA5});
      drain();
      setup(1, 4, 2);
      frame(1, 4, 0, 2, 0);                                 // no flushes:
      for (int i = 0; i < 9; i++)                           // pixels pad instead
         word_queue.push_back('{op: bf2d_pkg::OP_PIXEL, pixel: 8'($urandom)});
      drain();
      setup(4095, 1, 7);                                    // width clamps to 2048
      // not driven; only a register write, next setup restarts

      // Random frames, mostly small sizes, radius 0 to 7.
      sent = 0;
      while (sent < 1600) begin
         if (sent > 1350) quiet = 1'b1;
         r = $urandom_range(0, 7);
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 10);
         if ($urandom_range(0, 9) == 0) w = 8192 - $urandom_range(1, 3);  // clamps to max
         setup(w, h, r);
         w = eff_w(); h = eff_h();
         if (w > 16) begin
            setup(16, h, r);
            w = 16;
         end
         frame(w, h, r, 2, $urandom_range(0, 3) == 0 ? 5 : 0);
         sent += w * h + r * w + r;
         drain();
      end
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
